### rtl/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

  // Tolerance is an unsigned 0.16 fraction, so "one" sits at bit 16.
  localparam int TOL_W     = 16;
  localparam int ONE_SHIFT = 16;

  // Widest operand piece fed to one hardware multiplier.
  localparam int PIECE_W = 24;

  // Stage enables for the two-stage multiplier.
  typedef struct packed {
    logic s1;
    logic s2;
  } mul_en_t;

endpackage

### rtl/ptt_mul.sv
`timescale 1ns / 1ps

// Two-stage signed multiplier. Each operand is cut into pieces of at most
// PIECE_W bits; the partial products are registered in the first stage and
// summed with their shifts in the second.
module ptt_mul #(
  parameter int AW = 28,
  parameter int BW = 28
) (
  input  logic                     clk,
  input  ptt_pkg::mul_en_t         en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  localparam int KA = (AW + ptt_pkg::PIECE_W - 1) / ptt_pkg::PIECE_W;
  localparam int KB = (BW + ptt_pkg::PIECE_W - 1) / ptt_pkg::PIECE_W;
  localparam int PA = (AW + KA - 1) / KA;
  localparam int PB = (BW + KB - 1) / KB;
  localparam int RW = AW + BW;

  logic signed [KA*PA-1:0] a_ext;
  logic signed [KB*PB-1:0] b_ext;
  logic signed [PA:0]      a_pc [KA];
  logic signed [PB:0]      b_pc [KB];
  logic signed [PA+PB+1:0] pp_r [KA][KB];
  logic signed [RW-1:0]    acc;
  logic signed [RW-1:0]    p_r;

  assign a_ext = (KA*PA)'(a);
  assign b_ext = (KB*PB)'(b);

  // Only the top piece carries the sign; lower pieces are unsigned.
  for (genvar i = 0; i < KA; i++) begin : g_apc
    if (i == KA - 1) begin : g_top
      assign a_pc[i] = $signed({a_ext[i*PA+PA-1], a_ext[i*PA +: PA]});
    end else begin : g_low
      assign a_pc[i] = $signed({1'b0, a_ext[i*PA +: PA]});
    end
  end

  for (genvar j = 0; j < KB; j++) begin : g_bpc
    if (j == KB - 1) begin : g_top
      assign b_pc[j] = $signed({b_ext[j*PB+PB-1], b_ext[j*PB +: PB]});
    end else begin : g_low
      assign b_pc[j] = $signed({1'b0, b_ext[j*PB +: PB]});
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < KA; i++) begin
        for (int j = 0; j < KB; j++) begin
          pp_r[i][j] <= (PA+PB+2)'(a_pc[i]) * (PA+PB+2)'(b_pc[j]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < KA; i++) begin
      for (int j = 0; j < KB; j++) begin
        acc = acc + (RW'(pp_r[i][j]) <<< (i*PA + j*PB));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p_r <= acc;
    end
  end

  assign p = p_r;

endmodule

### rtl/point_in_triangle_test_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Direction
// input     in_valid/in_ready, in_point_*,          request in
//           in_corner_a_*, in_corner_b_*, in_corner_c_*
// result    out_valid/out_ready, out_inside_res,    request out
//           out_degenerate
// config    cfg_wr_en, cfg_wr_data                  write only
//
// A request passes through the nine registered stages to out_valid; one request
// enters per cycle unless a stall on out_ready has filled the whole pipe, since
// each stage, the two-stage multipliers among them, takes a new request whenever its content moves on.
// Reset clears the valid bits and the tolerance register.
// A stall on out_ready holds only the stages that are full; empty stages
// keep filling, so in_ready stays high until the whole pipe is occupied.

module point_in_triangle_test_core #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside_res,
  output logic                          out_degenerate,
  input  logic                          cfg_wr_en,
  input  logic [ptt_pkg::TOL_W-1:0]     cfg_wr_data
);

  localparam int NS  = 9;
  localparam int EW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * EW;
  localparam int DTW = PW + 2;
  localparam int MW  = 2 * DTW;
  localparam int DW  = MW + 1;
  localparam int TMW = ptt_pkg::TOL_W + 1;
  localparam int QW  = DW + TMW;
  localparam int SW  = DW + 2;
  localparam int TW  = DW + 19;

  // Stage indexes that drive the multiplier units.
  localparam int ST_DOT_MUL = 3;
  localparam int ST_TOL_MUL = 6;

  // Dot product indexes.
  localparam int D00 = 0;
  localparam int D01 = 1;
  localparam int D02 = 2;
  localparam int D11 = 3;
  localparam int D12 = 4;

  localparam int MA [6] = '{D00, D01, D11, D01, D00, D01};
  localparam int MB [6] = '{D11, D01, D02, D12, D12, D02};

  logic                    v_r [NS];
  logic                    en  [NS+1];
  logic [ptt_pkg::TOL_W-1:0] tol_r;

  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [COORD_WIDTH-1:0] ca [3];
  logic signed [COORD_WIDTH-1:0] cb [3];
  logic signed [COORD_WIDTH-1:0] cc [3];

  logic signed [EW-1:0]  e0_r [3];
  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic signed [PW-1:0]  prod_r [5][3];
  logic signed [DTW-1:0] dot_r [5];
  logic signed [MW-1:0]  mp [6];
  logic signed [DW-1:0]  den_r, nu_r, nv_r;
  logic signed [QW-1:0]  td;
  logic signed [DW-1:0]  nu7_r, nv7_r, nu8_r, nv8_r;
  logic signed [SW-1:0]  m7_r, m8_r;
  logic                  z7_r, z8_r;
  logic signed [TW-1:0]  t_u, t_v, t_w;
  logic                  inside_r, degen_r;

  assign pt = '{in_point_x, in_point_y, in_point_z};
  assign ca = '{in_corner_a_x, in_corner_a_y, in_corner_a_z};
  assign cb = '{in_corner_b_x, in_corner_b_y, in_corner_b_z};
  assign cc = '{in_corner_c_x, in_corner_c_y, in_corner_c_z};

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        v_r[k] <= 1'b0;
      end
      tol_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
    end
  end

  // Edge vectors C-A, B-A and P-A.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i] <= EW'(cc[i]) - EW'(ca[i]);
        e1_r[i] <= EW'(cb[i]) - EW'(ca[i]);
        e2_r[i] <= EW'(pt[i]) - EW'(ca[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[D00][i] <= PW'(e0_r[i]) * PW'(e0_r[i]);
        prod_r[D01][i] <= PW'(e0_r[i]) * PW'(e1_r[i]);
        prod_r[D02][i] <= PW'(e0_r[i]) * PW'(e2_r[i]);
        prod_r[D11][i] <= PW'(e1_r[i]) * PW'(e1_r[i]);
        prod_r[D12][i] <= PW'(e1_r[i]) * PW'(e2_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int d = 0; d < 5; d++) begin
        dot_r[d] <= DTW'(prod_r[d][0]) + DTW'(prod_r[d][1]) + DTW'(prod_r[d][2]);
      end
    end
  end

  for (genvar m = 0; m < 6; m++) begin : g_dmul
    ptt_mul #(
      .AW(DTW),
      .BW(DTW)
    ) u_mul (
      .clk(clk),
      .en ('{s1: en[ST_DOT_MUL], s2: en[ST_DOT_MUL+1]}),
      .a  (dot_r[MA[m]]),
      .b  (dot_r[MB[m]]),
      .p  (mp[m])
    );
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      den_r <= DW'(mp[0]) - DW'(mp[1]);
      nu_r  <= DW'(mp[2]) - DW'(mp[3]);
      nv_r  <= DW'(mp[4]) - DW'(mp[5]);
    end
  end

  // Tolerance slack scaled by the denominator.
  ptt_mul #(
    .AW(DW),
    .BW(TMW)
  ) u_tol_mul (
    .clk(clk),
    .en ('{s1: en[ST_TOL_MUL], s2: en[ST_TOL_MUL+1]}),
    .a  (den_r),
    .b  ($signed({1'b0, tol_r})),
    .p  (td)
  );

  // The upper bound becomes (den - nu - nv) * 65536 + tol * den >= 0.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      nu7_r <= nu_r;
      nv7_r <= nv_r;
      m7_r  <= SW'(den_r) - SW'(nu_r) - SW'(nv_r);
      z7_r  <= (den_r == '0);
    end
    if (en[7]) begin
      nu8_r <= nu7_r;
      nv8_r <= nv7_r;
      m8_r  <= m7_r;
      z8_r  <= z7_r;
    end
  end

  assign t_u = (TW'(nu8_r) <<< ptt_pkg::ONE_SHIFT) + TW'(td);
  assign t_v = (TW'(nv8_r) <<< ptt_pkg::ONE_SHIFT) + TW'(td);
  assign t_w = (TW'(m8_r)  <<< ptt_pkg::ONE_SHIFT) + TW'(td);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      degen_r  <= z8_r;
      inside_r <= !z8_r && !t_u[TW-1] && !t_v[TW-1] && !t_w[TW-1];
    end
  end

  assign out_inside_res = inside_r;
  assign out_degenerate = degen_r;

  a_degen_not_inside : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_res && out_degenerate))
    else $error("degenerate result reported as inside");

  a_empty_tail_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NS-1] |-> in_ready)
    else $error("input stalled while the output stage is empty");

  a_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (en[4] && v_r[3]) |=> v_r[4])
    else $error("request lost between multiplier stages");

  a_full_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && !out_ready) |=> v_r[NS-1])
    else $error("stalled result dropped");

endmodule
